// File: rtl/core/forbidden_word_masker_core_assert.svh
// Assertion macros shared by the RTL of the forbidden word masker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef FORBIDDEN_WORD_MASKER_CORE_ASSERT_SVH
`define FORBIDDEN_WORD_MASKER_CORE_ASSERT_SVH

// Same-cycle implication: the antecedent and the consequent are both sampled at one edge.
`define FWM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: the consequent is checked in the cycle after the antecedent.
`define FWM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/fwm_pkg.sv
`default_nettype none

package fwm_pkg;

    // Table and word sizes.
    localparam int MAX_WORDS    = 16;
    localparam int MAX_WORD_LEN = 16;
    localparam int COUNT_WIDTH  = 8;

    localparam int IDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int POS_W = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);
    localparam int TOT_W = $clog2(MAX_WORDS + 1);
    localparam int ADDR_W = IDX_W + POS_W;

    // Fixed field widths of the stream payloads.
    localparam int FUNC_W  = 3;
    localparam int CHAR_W  = 8;
    localparam int WIDX_W  = 4;
    localparam int HCNT_W  = 8;
    localparam int ODATA_W = 24;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic [CHAR_W-1:0] CHAR_ASTERISK = 8'd42;
    localparam logic [CHAR_W-1:0] CHAR_SPACE    = 8'd32;

    // Request function codes.
    localparam logic [FUNC_W-1:0] FUNC_CLEAR        = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_FORBID_CHAR  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_FORBID_END   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_COMMENT_CHAR = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_COMMENT_END  = 3'd4;

    // Result kinds.
    localparam logic KIND_CHAR   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP_LEN,
        ST_CMP_RD,
        ST_CMP_CHK,
        ST_EMIT_CHAR,
        ST_EMIT_SPACE,
        ST_REPORT
    } fsm_state_t;

endpackage

`default_nettype wire

// File: rtl/core/forbidden_word_masker_core.sv
`default_nettype none
// Channel  | Signals                          | Contents
// ---------+----------------------------------+-----------------------------------------
// Slave    | s_tvalid s_tready s_tdata s_tuser | tdata: ch; tuser: func
// Master   | m_tvalid m_tready m_tdata m_tuser | tdata: out_char, word_index, hit_count;
//          | m_tlast                          | tuser: kind; tlast: last
//
// Table loads, clears and plain comment characters are taken without leaving the idle state.
// A word end compares the word, unless it overflowed, against every loaded entry
// through one shared byte comparator: a length check for each entry, and where the
// lengths agree a registered read of the entry store and a check per compared
// character, up to the first mismatch; then each character and a space are emitted.
// An end of comment also emits a count report for each loaded entry.
// Reset is asynchronous and active low and leaves the table empty and all counts zero.
// No request is taken while a word is compared or emitted or counts are reported; a stalled
// master side holds the sequencer; one finished result may wait while a new request enters.

module forbidden_word_masker_core (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire  [fwm_pkg::CHAR_W-1:0]   s_tdata,  // [7:0] ch
    input  wire  [fwm_pkg::FUNC_W-1:0]   s_tuser,  // [2:0] func
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [fwm_pkg::ODATA_W-1:0]  m_tdata,  // [7:0] out_char, [11:8] word_index,
                                                   // [19:12] hit_count, [23:20] zero
    output logic                         m_tuser,  // [0] kind
    output logic                         m_tlast
);

    import fwm_pkg::*;

    // Sequencer state and control registers.
    fsm_state_t state_reg, state_next;

    logic [TOT_W-1:0]  total_reg, total_next;      // loaded entries
    logic [LEN_W-1:0]  loading_reg, loading_next;  // characters of the entry being loaded
    logic [LEN_W-1:0]  word_len_reg, word_len_next;
    logic              overflow_reg, overflow_next;
    logic              hit_reg, hit_next;          // current word matched some entry
    logic              report_reg, report_next;    // the flush belongs to an end of comment
    logic [IDX_W-1:0]  ent_reg, ent_next;          // entry under comparison or report
    logic [POS_W-1:0]  pos_reg, pos_next;          // character position in the word

    logic [COUNT_WIDTH-1:0] counts_reg [MAX_WORDS];
    logic [COUNT_WIDTH-1:0] counts_next [MAX_WORDS];

    // Stores without reset: never read before they are written.
    logic [CHAR_W-1:0] fchars_mem [2**ADDR_W];
    logic [LEN_W-1:0]  lengths_mem [MAX_WORDS];
    logic [CHAR_W-1:0] wbuf_mem [MAX_WORD_LEN];
    logic [CHAR_W-1:0] rd_data_reg;

    // Output register.
    logic              m_tvalid_reg;
    logic [CHAR_W-1:0] o_char_reg;
    logic [WIDX_W-1:0] o_idx_reg;
    logic [HCNT_W-1:0] o_cnt_reg;
    logic              o_kind_reg;
    logic              o_last_reg;

    logic              out_load;
    logic [CHAR_W-1:0] out_char;
    logic [WIDX_W-1:0] out_idx;
    logic [HCNT_W-1:0] out_cnt;
    logic              out_kind;
    logic              out_last;

    // Shared decode.
    logic              s_acc;
    logic              slot_free;
    logic              last_ent;
    logic              pos_last;
    logic              is_space;
    logic              word_nonempty;
    logic              flush_direct;  // word overflowed or no entry to compare against
    logic              len_eq;
    logic              char_eq;
    logic              wr_fchar;
    logic              wr_length;
    logic              wr_wbuf;
    logic [CHAR_W-1:0] wbuf_rd;

    assign s_tready      = (state_reg == ST_IDLE);
    assign s_acc         = s_tvalid && s_tready;
    assign slot_free     = !m_tvalid_reg || m_tready;
    assign last_ent      = ((TOT_W'(ent_reg) + TOT_W'(1)) == total_reg);
    assign pos_last      = ((LEN_W'(pos_reg) + LEN_W'(1)) == word_len_reg);
    assign is_space      = (s_tdata == CHAR_SPACE);
    assign word_nonempty = (word_len_reg != '0);
    assign flush_direct  = overflow_reg || (total_reg == '0);
    assign len_eq        = (lengths_mem[ent_reg] == word_len_reg);
    assign wbuf_rd       = wbuf_mem[pos_reg];
    assign char_eq       = (rd_data_reg == wbuf_rd);

    assign wr_fchar  = s_acc && (s_tuser == FUNC_FORBID_CHAR)
                       && (total_reg < TOT_W'(MAX_WORDS))
                       && (loading_reg < LEN_W'(MAX_WORD_LEN));
    assign wr_length = s_acc && (s_tuser == FUNC_FORBID_END)
                       && (total_reg < TOT_W'(MAX_WORDS)) && (loading_reg != '0);
    assign wr_wbuf   = s_acc && (s_tuser == FUNC_COMMENT_CHAR) && !is_space
                       && (word_len_reg < LEN_W'(MAX_WORD_LEN));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    if (((s_tuser == FUNC_COMMENT_CHAR) && is_space && word_nonempty)
                        || ((s_tuser == FUNC_COMMENT_END) && word_nonempty))
                    begin
                        state_next = flush_direct ? ST_EMIT_CHAR : ST_CMP_LEN;
                    end
                    else if ((s_tuser == FUNC_COMMENT_END) && (total_reg != '0))
                    begin
                        state_next = ST_REPORT;
                    end
                end
            end
            ST_CMP_LEN:
            begin
                if (len_eq)
                begin
                    state_next = ST_CMP_RD;
                end
                else if (last_ent)
                begin
                    state_next = ST_EMIT_CHAR;
                end
            end
            ST_CMP_RD:
            begin
                state_next = ST_CMP_CHK;
            end
            ST_CMP_CHK:
            begin
                if (!char_eq || pos_last)
                begin
                    state_next = last_ent ? ST_EMIT_CHAR : ST_CMP_LEN;
                end
                else
                begin
                    state_next = ST_CMP_RD;
                end
            end
            ST_EMIT_CHAR:
            begin
                if (slot_free && pos_last)
                begin
                    state_next = ST_EMIT_SPACE;
                end
            end
            ST_EMIT_SPACE:
            begin
                if (slot_free)
                begin
                    state_next = (report_reg && (total_reg != '0)) ? ST_REPORT : ST_IDLE;
                end
            end
            ST_REPORT:
            begin
                if (slot_free && last_ent)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and result selection.
    always_comb
    begin
        total_next    = total_reg;
        loading_next  = loading_reg;
        word_len_next = word_len_reg;
        overflow_next = overflow_reg;
        hit_next      = hit_reg;
        report_next   = report_reg;
        ent_next      = ent_reg;
        pos_next      = pos_reg;
        counts_next   = counts_reg;
        out_load      = 1'b0;
        out_char      = '0;
        out_idx       = '0;
        out_cnt       = '0;
        out_kind      = KIND_CHAR;
        out_last      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    // Every flush starts from the first entry and the first character.
                    ent_next    = '0;
                    pos_next    = '0;
                    hit_next    = 1'b0;
                    report_next = (s_tuser == FUNC_COMMENT_END);
                    unique case (s_tuser)
                        FUNC_CLEAR:
                        begin
                            total_next   = '0;
                            loading_next = '0;
                            for (int k = 0; k < MAX_WORDS; k++)
                            begin
                                counts_next[k] = '0;
                            end
                        end
                        FUNC_FORBID_CHAR:
                        begin
                            if (wr_fchar)
                            begin
                                loading_next = loading_reg + LEN_W'(1);
                            end
                        end
                        FUNC_FORBID_END:
                        begin
                            if (wr_length)
                            begin
                                total_next   = total_reg + TOT_W'(1);
                                loading_next = '0;
                            end
                        end
                        FUNC_COMMENT_CHAR:
                        begin
                            if (wr_wbuf)
                            begin
                                word_len_next = word_len_reg + LEN_W'(1);
                            end
                            else if (!is_space)
                            begin
                                overflow_next = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CMP_LEN:
            begin
                pos_next = '0;
                if (!len_eq)
                begin
                    ent_next = ent_reg + IDX_W'(1);
                end
            end
            ST_CMP_RD:
            begin
            end
            ST_CMP_CHK:
            begin
                if (!char_eq || pos_last)
                begin
                    if (char_eq)
                    begin
                        hit_next = 1'b1;
                        if (counts_reg[ent_reg] != COUNT_MAX)
                        begin
                            counts_next[ent_reg] = counts_reg[ent_reg] + COUNT_WIDTH'(1);
                        end
                    end
                    ent_next = ent_reg + IDX_W'(1);
                    pos_next = '0;
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
            ST_EMIT_CHAR:
            begin
                if (slot_free)
                begin
                    out_load = 1'b1;
                    out_char = hit_reg ? CHAR_ASTERISK : wbuf_rd;
                    pos_next = pos_reg + POS_W'(1);
                end
            end
            ST_EMIT_SPACE:
            begin
                if (slot_free)
                begin
                    out_load      = 1'b1;
                    out_char      = CHAR_SPACE;
                    out_last      = !(report_reg && (total_reg != '0));
                    word_len_next = '0;
                    overflow_next = 1'b0;
                    ent_next      = '0;
                end
            end
            ST_REPORT:
            begin
                if (slot_free)
                begin
                    out_load             = 1'b1;
                    out_kind             = KIND_REPORT;
                    out_idx              = WIDX_W'(ent_reg);
                    out_cnt              = HCNT_W'(counts_reg[ent_reg]);
                    out_last             = last_ent;
                    counts_next[ent_reg] = '0;
                    ent_next             = ent_reg + IDX_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            total_reg    <= '0;
            loading_reg  <= '0;
            word_len_reg <= '0;
            overflow_reg <= 1'b0;
            hit_reg      <= 1'b0;
            report_reg   <= 1'b0;
            ent_reg      <= '0;
            pos_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            for (int k = 0; k < MAX_WORDS; k++)
            begin
                counts_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            loading_reg  <= loading_next;
            word_len_reg <= word_len_next;
            overflow_reg <= overflow_next;
            hit_reg      <= hit_next;
            report_reg   <= report_next;
            ent_reg      <= ent_next;
            pos_reg      <= pos_next;
            counts_reg   <= counts_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            o_char_reg <= out_char;
            o_idx_reg  <= out_idx;
            o_cnt_reg  <= out_cnt;
            o_kind_reg <= out_kind;
            o_last_reg <= out_last;
        end
    end

    // Entry character store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_fchar)
        begin
            fchars_mem[{total_reg[IDX_W-1:0], loading_reg[POS_W-1:0]}] <= s_tdata;
        end
        if (state_reg == ST_CMP_RD)
        begin
            rd_data_reg <= fchars_mem[{ent_reg, pos_reg}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_length)
        begin
            lengths_mem[total_reg[IDX_W-1:0]] <= loading_reg;
        end
        if (wr_wbuf)
        begin
            wbuf_mem[word_len_reg[POS_W-1:0]] <= s_tdata;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(ODATA_W - CHAR_W - WIDX_W - HCNT_W)'(0), o_cnt_reg, o_idx_reg, o_char_reg};
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;

`include "forbidden_word_masker_core_assert.svh"

    `FWM_ASSERT_IMPL(a_total_bound, 1'b1, total_reg <= TOT_W'(MAX_WORDS), "table count too large")
    `FWM_ASSERT_IMPL(a_word_bound, 1'b1, word_len_reg <= LEN_W'(MAX_WORD_LEN), "word too long")
    `FWM_ASSERT_IMPL(a_cmp_clean, (state_reg == ST_CMP_LEN) || (state_reg == ST_CMP_CHK), !overflow_reg && word_nonempty && (total_reg != '0), "compare of an unmatchable word")
    `FWM_ASSERT_NEXT(a_empty_end, s_acc && (s_tuser == FUNC_COMMENT_END) && !word_nonempty && (total_reg == '0), state_reg == ST_IDLE, "empty end of comment left idle")

endmodule

`default_nettype wire

// File: sim/tb_forbidden_word_masker_core.sv
`default_nettype none

// Self-checking bench for the forbidden word masker. Requests are queued up
// front by an initial block; a clocked driver offers them on the slave stream
// and a clocked monitor takes results from the master stream and compares
// them, oldest first, against what the in-bench filter model predicted when
// each request was accepted.

module tb_forbidden_word_masker_core;
    import fwm_pkg::*;

    // Run shape.
    localparam int RANDOM_ITEMS  = 400;
    localparam int HIT_RUN       = 20;    // matching words in the directed hit run
    localparam int CALM_TAIL     = 80;    // no idling on either side for the last requests
    localparam int PRESSURE_AT   = 60;    // request count at which the long stall starts
    localparam int HOLD_CYCLES   = 300;   // length of that receiver stall
    localparam int STALL_LIMIT   = 4000;  // cycles without any handshake before giving up
    localparam int SETTLE_CYCLES = 64;

    // Function codes the block does not know; they must be swallowed silently.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;

    // Start of the small alphabet that makes random words collide with the table.
    localparam logic [CHAR_W-1:0] CHAR_A = 8'h61;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CHAR_W-1:0] ch;
    } masker_req_t;

    typedef struct packed {
        logic              kind;
        logic [CHAR_W-1:0] out_char;
        logic [WIDX_W-1:0] word_index;
        logic [HCNT_W-1:0] hit_count;
        logic              last;
    } masker_result_t;

    logic clk;
    logic rst_n = 1'b0;

    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [CHAR_W-1:0]  s_tdata  = '0;   // [7:0] ch
    logic [FUNC_W-1:0]  s_tuser  = '0;   // [2:0] func
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [ODATA_W-1:0] m_tdata;         // [7:0] out_char, [11:8] word_index, [19:12] hit_count
    logic               m_tuser;         // [0] kind
    logic               m_tlast;

    forbidden_word_masker_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Filter model: its own copy of the word table, the comment word being
    // collected and the per-entry hit counters.
    // ------------------------------------------------------------------
    logic [CHAR_W-1:0]      tbl_chars [MAX_WORDS*MAX_WORD_LEN];
    int                     tbl_len   [MAX_WORDS];
    int                     tbl_total = 0;
    int                     load_len  = 0;
    logic [CHAR_W-1:0]      word_buf  [MAX_WORD_LEN];
    int                     word_len  = 0;
    bit                     word_ovf  = 1'b0;
    logic [COUNT_WIDTH-1:0] hits      [MAX_WORDS] = '{default: '0};

    masker_result_t request_outputs[$];    // results of the request being modelled
    masker_result_t filtered_stream_q[$];  // results still owed by the block

    task automatic add_output(input logic k, input logic [CHAR_W-1:0] c,
                              input logic [WIDX_W-1:0] idx, input logic [HCNT_W-1:0] cnt);
        masker_result_t r;
        r.kind       = k;
        r.out_char   = c;
        r.word_index = idx;
        r.hit_count  = cnt;
        r.last       = 1'b0;
        request_outputs.push_back(r);
    endtask

    // Closes the comment word: compares it with every loaded entry, bumps the
    // counters of all matching entries and emits the word (masked or not) and
    // a space. An overflowed word is never compared.
    task automatic close_comment_word();
        bit masked;
        bit same;
        masked = 1'b0;
        if (word_len == 0)
            return;
        if (!word_ovf)
        begin
            for (int e = 0; e < tbl_total; e++)
            begin
                same = (tbl_len[e] == word_len);
                for (int i = 0; i < word_len && same; i++)
                    if (tbl_chars[e*MAX_WORD_LEN + i] != word_buf[i])
                        same = 1'b0;
                if (same)
                begin
                    masked = 1'b1;
                    if (hits[e] != COUNT_MAX)
                        hits[e]++;
                end
            end
        end
        for (int i = 0; i < word_len; i++)
            add_output(KIND_CHAR, masked ? CHAR_ASTERISK : word_buf[i], '0, '0);
        add_output(KIND_CHAR, CHAR_SPACE, '0, '0);
        word_len = 0;
        word_ovf = 1'b0;
    endtask

    task automatic apply_filter_request(input masker_req_t req);
        request_outputs.delete();
        case (req.func)
            FUNC_CLEAR:
            begin
                // The comment word in progress survives a clear.
                tbl_total = 0;
                load_len  = 0;
                foreach (hits[e])
                    hits[e] = '0;
            end
            FUNC_FORBID_CHAR:
            begin
                if (tbl_total < MAX_WORDS && load_len < MAX_WORD_LEN)
                begin
                    tbl_chars[tbl_total*MAX_WORD_LEN + load_len] = req.ch;
                    load_len++;
                end
            end
            FUNC_FORBID_END:
            begin
                if (tbl_total < MAX_WORDS && load_len > 0)
                begin
                    tbl_len[tbl_total] = load_len;
                    tbl_total++;
                    load_len = 0;
                end
            end
            FUNC_COMMENT_CHAR:
            begin
                if (req.ch == CHAR_SPACE)
                    close_comment_word();
                else if (word_len < MAX_WORD_LEN)
                begin
                    word_buf[word_len] = req.ch;
                    word_len++;
                end
                else
                    word_ovf = 1'b1;
            end
            FUNC_COMMENT_END:
            begin
                close_comment_word();
                for (int e = 0; e < tbl_total; e++)
                begin
                    add_output(KIND_REPORT, '0, WIDX_W'(e), HCNT_W'(hits[e]));
                    hits[e] = '0;
                end
            end
            default: ;
        endcase
        if (request_outputs.size() != 0)
        begin
            request_outputs[request_outputs.size()-1].last = 1'b1;
            foreach (request_outputs[i])
                filtered_stream_q.push_back(request_outputs[i]);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus construction. Everything is queued before reset is released.
    // ------------------------------------------------------------------
    masker_req_t     pending_reqs[$];
    int              total_reqs = 0;

    // Progress and error counts shared by the driver, the monitor and the end of run.
    int              reqs_taken   = 0;
    int              results_seen = 0;
    int              errors       = 0;

    // Words loaded into the table by the most recent sessions, reused in
    // comments so that a good share of comment words actually match.
    logic [CHAR_W-1:0] vocab_chars [MAX_WORDS][24];
    int                vocab_len   [MAX_WORDS];
    int                vocab_cnt = 0;

    task automatic add_req(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] c);
        masker_req_t r;
        r.func = f;
        r.ch   = c;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [CHAR_W-1:0] pick_char(input bit wide);
        if (wide)
            return CHAR_W'($urandom_range(0, 255));
        return CHAR_A + CHAR_W'($urandom_range(0, 3));
    endfunction

    // Loads a table. A big load goes past the number of entries and starts
    // with an entry longer than the word limit.
    task automatic load_forbidden_words(input bit big);
        int  n;
        int  len;
        bit  wide;
        logic [CHAR_W-1:0] c;
        if (big || $urandom_range(0, 3) != 0)
        begin
            add_req(FUNC_CLEAR, pick_char(1'b1));
            vocab_cnt = 0;
        end
        n = big ? MAX_WORDS + 1 : $urandom_range(1, 4);
        for (int e = 0; e < n; e++)
        begin
            if ((big && e == 0) || $urandom_range(0, 9) == 0)
                len = MAX_WORD_LEN + $urandom_range(1, 3);
            else
                len = $urandom_range(1, 4);
            wide = ($urandom_range(0, 7) == 0);
            for (int i = 0; i < len; i++)
            begin
                c = pick_char(wide);
                add_req(FUNC_FORBID_CHAR, c);
                if (vocab_cnt < MAX_WORDS)
                    vocab_chars[vocab_cnt][i] = c;
            end
            if (vocab_cnt < MAX_WORDS)
            begin
                vocab_len[vocab_cnt] = len;
                vocab_cnt++;
            end
            add_req(FUNC_FORBID_END, pick_char(1'b1));
            // Now and then a second word end with nothing loaded behind it.
            if ($urandom_range(0, 9) == 0)
                add_req(FUNC_FORBID_END, pick_char(1'b1));
        end
    endtask

    // A comment of a few words, some taken from the table, some random, some
    // too long; occasional double spaces and stray requests in between.
    task automatic write_comment();
        int  n;
        int  k;
        int  len;
        bit  wide;
        n = $urandom_range(2, 8);
        for (int w = 0; w < n; w++)
        begin
            if (vocab_cnt > 0 && $urandom_range(0, 1) == 1)
            begin
                k = $urandom_range(0, vocab_cnt - 1);
                for (int i = 0; i < vocab_len[k]; i++)
                    add_req(FUNC_COMMENT_CHAR, vocab_chars[k][i]);
            end
            else
            begin
                len  = ($urandom_range(0, 9) == 0) ? MAX_WORD_LEN + $urandom_range(1, 3)
                                                   : $urandom_range(1, 5);
                wide = ($urandom_range(0, 4) == 0);
                for (int i = 0; i < len; i++)
                    add_req(FUNC_COMMENT_CHAR, pick_char(wide));
            end
            // The last word is often left for the end of comment to flush.
            if (w != n - 1 || $urandom_range(0, 1) == 1)
                repeat (($urandom_range(0, 4) == 0) ? 2 : 1)
                    add_req(FUNC_COMMENT_CHAR, CHAR_SPACE);
            if ($urandom_range(0, 11) == 0)
                add_req(FUNC_W'($urandom_range(0, 7)), CHAR_W'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 7) != 0)
            add_req(FUNC_COMMENT_END, CHAR_W'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int base;
        bit big;

        // Directed opening.
        add_req(FUNC_COMMENT_END, 8'h00);        // nothing to flush, empty table: silent
        add_req(FUNC_FORBID_END, 8'hFF);         // word end with no characters: ignored
        add_req(FUNC_FORBID_CHAR, CHAR_A);
        add_req(FUNC_FORBID_CHAR, CHAR_A + 8'd1);
        add_req(FUNC_FORBID_END, 8'h00);
        add_req(FUNC_FORBID_CHAR, CHAR_SPACE);   // a space inside an entry is stored
        add_req(FUNC_FORBID_CHAR, 8'hFF);
        add_req(FUNC_FORBID_END, 8'hFF);
        add_req(FUNC_COMMENT_CHAR, CHAR_SPACE);  // empty words give nothing
        add_req(FUNC_COMMENT_CHAR, CHAR_SPACE);
        add_req(FUNC_COMMENT_CHAR, CHAR_A);      // matches the first entry
        add_req(FUNC_COMMENT_CHAR, CHAR_A + 8'd1);
        add_req(FUNC_COMMENT_CHAR, CHAR_SPACE);
        add_req(FUNC_COMMENT_CHAR, 8'h00);
        add_req(FUNC_COMMENT_CHAR, 8'hFF);
        add_req(FUNC_UNUSED_LO, 8'hFF);
        add_req(FUNC_UNUSED_LO + 3'd1, 8'h55);
        add_req(FUNC_UNUSED_HI, 8'h00);
        add_req(FUNC_COMMENT_END, 8'hFF);        // flushes the open word, reports both entries
        add_req(FUNC_COMMENT_CHAR, CHAR_A);
        add_req(FUNC_CLEAR, 8'hFF);              // word in progress must survive
        add_req(FUNC_COMMENT_CHAR, CHAR_A + 8'd1);
        add_req(FUNC_COMMENT_END, 8'h00);

        // A run of hits on one single-letter entry. The long receiver stall
        // falls inside this run.
        add_req(FUNC_CLEAR, 8'h00);
        add_req(FUNC_FORBID_CHAR, CHAR_A);
        add_req(FUNC_FORBID_END, 8'h00);
        repeat (HIT_RUN)
        begin
            add_req(FUNC_COMMENT_CHAR, CHAR_A);
            add_req(FUNC_COMMENT_CHAR, CHAR_SPACE);
        end
        add_req(FUNC_COMMENT_END, 8'hFF);

        // Random sessions of table load followed by comments; the first one
        // overfills the table.
        base = pending_reqs.size();
        big  = 1'b1;
        while (pending_reqs.size() - base < RANDOM_ITEMS)
        begin
            load_forbidden_words(big);
            big = 1'b0;
            repeat ($urandom_range(1, 3))
                write_comment();
        end
        total_reqs = pending_reqs.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Wait on the falling edge so that the driver and monitor have
        // finished their work for the rising edge before we look.
        while (reqs_taken != total_reqs || filtered_stream_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("PASS forbidden_word_masker_core");
        else
            $display("FAIL forbidden_word_masker_core");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: offers queued requests, idling in short bursts except during
    // calm stretches and the tail of the run. Each request is fed to the
    // filter model at the edge where it is accepted.
    // ------------------------------------------------------------------
    int          tx_gap       = 0;
    masker_req_t tx_req;
    wire         tx_may_idle = (reqs_taken % 96) < 64 && reqs_taken + CALM_TAIL < total_reqs;
    wire         rx_may_idle = (results_seen % 96) < 64 && reqs_taken + CALM_TAIL < total_reqs;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= '0;
            reqs_taken <= 0;
            tx_gap      = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                apply_filter_request(tx_req);
                reqs_taken <= reqs_taken + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (tx_may_idle && $urandom_range(0, 3) == 0)
                begin
                    tx_gap = $urandom_range(0, 2);
                    s_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    tx_req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= tx_req.ch;
                    s_tuser  <= tx_req.func;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted result and paces m_tready. Once, a long
    // hold-off lets the block back up until it refuses requests.
    // ------------------------------------------------------------------
    int             rx_gap        = 0;
    int             hold_left     = 0;
    bit             pressure_done = 1'b0;
    masker_result_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready     <= 1'b0;
            results_seen <= 0;
            rx_gap        = 0;
            hold_left     = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                if (filtered_stream_q.size() == 0)
                begin
                    $error("result with nothing expected: kind %0d tdata 0x%06h last %0d",
                           m_tuser, m_tdata, m_tlast);
                    errors++;
                end
                else
                begin
                    want = filtered_stream_q.pop_front();
                    if (m_tuser !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, m_tuser);
                        errors++;
                    end
                    if (m_tdata[7:0] !== want.out_char)
                    begin
                        $error("out_char: expected %0d, got %0d", want.out_char, m_tdata[7:0]);
                        errors++;
                    end
                    if (m_tdata[11:8] !== want.word_index)
                    begin
                        $error("word_index: expected %0d, got %0d",
                               want.word_index, m_tdata[11:8]);
                        errors++;
                    end
                    if (m_tdata[19:12] !== want.hit_count)
                    begin
                        $error("hit_count: expected %0d, got %0d",
                               want.hit_count, m_tdata[19:12]);
                        errors++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, m_tlast);
                        errors++;
                    end
                end
            end

            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!pressure_done && reqs_taken >= PRESSURE_AT)
            begin
                pressure_done = 1'b1;
                hold_left     = HOLD_CYCLES - 1;
                m_tready     <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                m_tready <= 1'b0;
            end
            else if (rx_may_idle && $urandom_range(0, 3) == 0)
            begin
                rx_gap = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog: a word end against a full table of long entries plus the long
    // receiver stall stays well under this many quiet cycles.
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("FAIL forbidden_word_masker_core");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl/core
rtl/core/fwm_pkg.sv
rtl/core/forbidden_word_masker_core.sv
sim/tb_forbidden_word_masker_core.sv
